@@ src/acfp_pkg.sv @@
// Package: shared types, constants and a helper function of the command frame parser.
package acfp_pkg;

  localparam int unsigned MAX_CMD_DEF = 64;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [APB_AW-1:0] REG_SUM_MASK = 3'd0;
  localparam logic [31:0]       MASK_RESET   = 32'h0000_00FF;

  localparam logic [7:0] CH_START = 8'h3E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PR_LO = 8'h20;
  localparam logic [7:0] CH_PR_HI = 8'h7E;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_SUM  = 2'd2
  } phase_e;

  typedef struct packed {
    logic       cmd_ready;
    logic       dropped;
    logic [6:0] length;
    logic       rd_hit;
  } acfp_res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ src/acfp_if.sv @@
// Interfaces: input item channel and result item channel.
interface acfp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_in;
  logic [6:0] read_index;

  modport source (output valid, func, char_in, read_index, input ready);
  modport sink   (input valid, func, char_in, read_index, output ready);
endinterface

interface acfp_out_if;
  logic       valid;
  logic       ready;
  logic       command_ready;
  logic       frame_dropped;
  logic [6:0] command_length;
  logic [7:0] read_data;

  modport source (output valid, command_ready, frame_dropped, command_length, read_data,
                  input ready);
  modport sink   (input valid, command_ready, frame_dropped, command_length, read_data,
                  output ready);
endinterface

@@ src/acfp_ram.sv @@
// Generic simple dual-port RAM with registered read.
module acfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 130
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/acfp_parser.sv @@
// Parser: frame state registers, frame store write and read address generation.
module acfp_parser import acfp_pkg::*; #(
  parameter int unsigned MAX_CMD = MAX_CMD_DEF,
  parameter int unsigned ADDR_W  = $clog2(2 * (MAX_CMD + 1))
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              func_i,
  input  logic [7:0]        char_in_i,
  input  logic [6:0]        read_index_i,
  input  logic [31:0]       mask_i,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  output acfp_res_t         res_o
);

  localparam int unsigned BANK  = MAX_CMD + 1;
  localparam int unsigned CNT_W = $clog2(BANK + 1);
  localparam logic [CNT_W-1:0] BANK_C = CNT_W'(BANK);

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  wcnt_q, wcnt_d;
  logic [15:0]       sum_q, sum_d;
  logic [31:0]       rval_q, rval_d;
  logic              seen_q, seen_d;
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  plen_q, plen_d;

  logic [4:0] hex;
  logic       is_eol;
  logic       is_print;
  logic       we;
  logic       rdy;
  logic       drop;

  always_comb begin
    hex      = hex_digit(char_in_i);
    is_eol   = (char_in_i == CH_CR) || (char_in_i == CH_LF);
    is_print = (char_in_i >= CH_PR_LO) && (char_in_i <= CH_PR_HI);
    phase_d  = phase_q;
    wcnt_d   = wcnt_q;
    sum_d    = sum_q;
    rval_d   = rval_q;
    seen_d   = seen_q;
    bank_d   = bank_q;
    plen_d   = plen_q;
    we       = 1'b0;
    rdy      = 1'b0;
    drop     = 1'b0;
    if (func_i == FUNC_CHAR) begin
      case (phase_q)
        PH_IDLE: begin
          if (char_in_i == CH_START) begin
            phase_d = PH_BODY;
            wcnt_d  = '0;
            sum_d   = '0;
            rval_d  = '0;
            seen_d  = 1'b0;
          end
        end
        PH_BODY: begin
          if (char_in_i == CH_SEMI) begin
            phase_d = PH_SUM;
            rval_d  = '0;
            seen_d  = 1'b0;
          end else if (is_print) begin
            if (wcnt_q < BANK_C) begin
              we     = 1'b1;
              wcnt_d = wcnt_q + 1'b1;
              sum_d  = sum_q + 16'(char_in_i);
            end else begin
              drop = 1'b1;
            end
          end else if (is_eol) begin
            rdy = 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        PH_SUM: begin
          if (hex[4]) begin
            rval_d = {rval_q[27:0], hex[3:0]};
            seen_d = 1'b1;
          end else if (is_eol) begin
            if (seen_q && (rval_q == ({16'd0, sum_q} & mask_i))) begin
              rdy = 1'b1;
            end else begin
              drop = 1'b1;
            end
          end else begin
            drop = 1'b1;
          end
        end
        default: begin
          drop = 1'b1;
        end
      endcase
      if (rdy) begin
        bank_d = ~bank_q;
        plen_d = wcnt_q;
      end
      if (rdy || drop) begin
        phase_d = PH_IDLE;
        wcnt_d  = '0;
        sum_d   = '0;
        rval_d  = '0;
        seen_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wcnt_q  <= '0;
      sum_q   <= '0;
      rval_q  <= '0;
      seen_q  <= 1'b0;
      bank_q  <= 1'b0;
      plen_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wcnt_q  <= wcnt_d;
      sum_q   <= sum_d;
      rval_q  <= rval_d;
      seen_q  <= seen_d;
      bank_q  <= bank_d;
      plen_q  <= plen_d;
    end
  end

  // New text goes to the bank that is not published
  assign ram_we_o    = accept_i && we;
  assign ram_waddr_o = ADDR_W'(32'(wcnt_q) + (bank_q ? 32'd0 : 32'(BANK)));
  assign ram_wdata_o = char_in_i;
  assign ram_re_o    = accept_i && (func_i == FUNC_READ);
  assign ram_raddr_o = ADDR_W'(32'(read_index_i) + (bank_q ? 32'(BANK) : 32'd0));

  always_comb begin
    res_o.cmd_ready = rdy;
    res_o.dropped   = drop;
    res_o.length    = 7'(plen_d);
    res_o.rd_hit    = (func_i == FUNC_READ) && (32'(read_index_i) < 32'(plen_q));
  end

endmodule

@@ src/acfp_out.sv @@
// Result stage: aligns the frame store read data and holds results in an output register.
module acfp_out import acfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  acfp_res_t   res_i,
  input  logic [7:0]  rdata_i,
  output logic        in_ready_o,
  acfp_out_if.source  out_o
);

  logic      s1_valid_q;
  acfp_res_t s1_res_q;
  logic      out_valid_q;
  logic      out_rdy_q;
  logic      out_drop_q;
  logic [6:0] out_len_q;
  logic [7:0] out_data_q;
  logic       s1_adv;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= accept_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && accept_i) begin
      s1_res_q <= res_i;
    end
    if (s1_adv && s1_valid_q) begin
      out_rdy_q  <= s1_res_q.cmd_ready;
      out_drop_q <= s1_res_q.dropped;
      out_len_q  <= s1_res_q.length;
      out_data_q <= s1_res_q.rd_hit ? rdata_i : 8'd0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.command_ready  = out_rdy_q;
  assign out_o.frame_dropped  = out_drop_q;
  assign out_o.command_length = out_len_q;
  assign out_o.read_data      = out_data_q;

endmodule

@@ src/ascii_command_frame_parser_unit.sv @@
// Top level: ASCII command frame parser with additive hex checksum and APB register.
//
//   channel  | dir | handshake        | payload
//   in_i     | in  | valid/ready      | func, char_in, read_index
//   out_o    | out | valid/ready      | command_ready, frame_dropped, command_length, read_data
//   apb      | in  | psel/penable     | paddr, pwdata, prdata (sum mask at 0x0)
//
// One item accepted per cycle while input ready is high; each result passes through the frame
// store read stage, then the output register. The read stage covers the registered read of the store.
// Reset clears parser state, the sum mask and the output valid flags; the store needs no clearing pass.
// A stalled output holds one result plus one in flight before input ready drops.
module ascii_command_frame_parser_unit import acfp_pkg::*; #(
  parameter int unsigned MAX_CMD = MAX_CMD_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  acfp_in_if.sink           in_i,
  acfp_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned DEPTH  = 2 * (MAX_CMD + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [31:0]       mask_q;
  logic              accept;
  logic              in_ready;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  acfp_res_t         res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SUM_MASK) ? mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MASK_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_SUM_MASK)) begin
      mask_q <= pwdata;
    end
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  acfp_parser #(
    .MAX_CMD (MAX_CMD),
    .ADDR_W  (ADDR_W)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (in_i.func),
    .char_in_i    (in_i.char_in),
    .read_index_i (in_i.read_index),
    .mask_i       (mask_q),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .res_o        (res)
  );

  acfp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  acfp_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_i      (res),
    .rdata_i    (ram_rdata),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

@@ bench/testbench.sv @@
// Testbench: random and directed frame streams against a behavioral parser model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acfp_pkg::*;

  localparam int BANK = MAX_CMD_DEF + 1;

  typedef struct packed {
    logic       ready;
    logic       dropped;
    logic [6:0] length;
    logic [7:0] data;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  acfp_in_if  in_ch ();
  acfp_out_if out_ch ();

  ascii_command_frame_parser_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  phase_e      phase_m   = PH_IDLE;
  logic [6:0]  wr_cnt_m  = '0;
  logic [15:0] sum_m     = '0;
  logic [31:0] rx_val_m  = '0;
  logic        digit_m   = 1'b0;
  logic [7:0]  text_m [0:2*BANK-1];
  logic        bank_m    = 1'b0;
  logic [6:0]  pub_len_m = '0;
  logic [31:0] mask_m    = MASK_RESET;

  parse_result_t expected_results[$];
  int error_count = 0;
  int item_count  = 0;
  int out_stall   = 0;
  bit in_calm     = 1'b0;
  bit out_calm    = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void clear_frame();
    phase_m  = PH_IDLE;
    wr_cnt_m = '0;
    sum_m    = '0;
    rx_val_m = '0;
    digit_m  = 1'b0;
  endfunction

  function automatic void publish_frame();
    bank_m    = !bank_m;
    pub_len_m = wr_cnt_m;
  endfunction

  function automatic parse_result_t predict_parser_step(input logic f, input logic [7:0] c,
                                                        input logic [6:0] idx);
    parse_result_t res;
    logic [4:0] nib;
    int base;
    res  = '0;
    nib  = '0;
    base = bank_m ? 0 : BANK;
    if (f == FUNC_READ) begin
      if (idx < pub_len_m && idx < BANK) res.data = text_m[(bank_m ? BANK : 0) + idx];
    end else if (phase_m == PH_IDLE) begin
      if (c == CH_START) begin
        clear_frame();
        phase_m = PH_BODY;
      end
    end else if (phase_m == PH_BODY) begin
      if (c == CH_SEMI) begin
        phase_m  = PH_SUM;
        rx_val_m = '0;
        digit_m  = 1'b0;
      end else if (c >= CH_PR_LO && c <= CH_PR_HI) begin
        if (wr_cnt_m < BANK) begin
          text_m[base + wr_cnt_m] = c;
          wr_cnt_m = wr_cnt_m + 7'd1;
          sum_m    = sum_m + 16'(c);
        end else begin
          res.dropped = 1'b1;
          clear_frame();
        end
      end else if (c == CH_CR || c == CH_LF) begin
        publish_frame();
        res.ready = 1'b1;
        clear_frame();
      end else begin
        res.dropped = 1'b1;
        clear_frame();
      end
    end else begin
      if (c >= "0" && c <= "9") begin
        nib = {1'b1, c[3:0]};
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
        nib = {1'b1, c[3:0] + 4'd9};
      end
      if (nib[4]) begin
        rx_val_m = {rx_val_m[27:0], nib[3:0]};
        digit_m  = 1'b1;
      end else if (c == CH_CR || c == CH_LF) begin
        if (digit_m && rx_val_m == ({16'h0, sum_m} & mask_m)) begin
          publish_frame();
          res.ready = 1'b1;
        end else begin
          res.dropped = 1'b1;
        end
        clear_frame();
      end else begin
        res.dropped = 1'b1;
        clear_frame();
      end
    end
    res.length = pub_len_m;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40) begin
      $display("%0t: mismatch on %s, got %0h, want %0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected item", 32'd0, 32'd0);
      return;
    end
    want = expected_results.pop_front();
    if (out_ch.command_ready !== want.ready)
      report_mismatch("command_ready", out_ch.command_ready, want.ready);
    if (out_ch.frame_dropped !== want.dropped)
      report_mismatch("frame_dropped", out_ch.frame_dropped, want.dropped);
    if (out_ch.command_length !== want.length)
      report_mismatch("command_length", out_ch.command_length, want.length);
    if (out_ch.read_data !== want.data)
      report_mismatch("read_data", out_ch.read_data, want.data);
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_ch.valid && out_ch.ready) check_result();
    if ($urandom_range(0, 255) == 0) out_calm = ($urandom_range(0, 2) == 0);
    if (out_calm || out_stall == 0) begin
      out_ch.ready <= 1'b1;
      out_stall = out_calm ? 0 : pick_gap();
    end else begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end
  end

  task automatic send_item(input logic f, input logic [7:0] c, input logic [6:0] idx);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.char_in    <= c;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    if (f == FUNC_READ || phase_m != PH_IDLE || c == CH_START) item_count++;
    expected_results.push_back(predict_parser_step(f, c, idx));
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(FUNC_CHAR, c, 7'($urandom));
  endtask

  task automatic send_read(input logic [6:0] idx);
    send_item(FUNC_READ, 8'($urandom), idx);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_PR_LO, CH_PR_HI)); while (c == CH_SEMI);
    return c;
  endfunction

  task automatic send_hex(input logic [31:0] value, input int ndig, input int extra);
    for (int k = ndig + extra - 1; k >= 0; k--) begin
      send_char(hex_char(k >= ndig ? 4'($urandom) : value[4*k +: 4]));
    end
  endtask

  task automatic send_frame();
    int r, len, kind, ndig;
    logic [15:0] sum;
    logic [31:0] value;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 75) len = $urandom_range(0, 12);
    else if (r < 92) len = $urandom_range(13, MAX_CMD_DEF);
    else if (r < 96) len = BANK;
    else len = $urandom_range(BANK + 1, BANK + 3);
    in_calm = ($urandom_range(0, 3) == 0);
    sum = '0;
    send_char(CH_START);
    for (int i = 0; i < len; i++) begin
      c = body_char();
      sum = sum + 16'(c);
      send_char(c);
    end
    value = {16'h0, sum} & mask_m;
    ndig = 1;
    while (ndig < 8 && (value >> (4 * ndig)) != 0) ndig++;
    kind = $urandom_range(0, 99);
    if (kind >= 40 && kind < 92) send_char(CH_SEMI);
    if (kind >= 40 && kind < 70) begin
      send_hex(value, $urandom_range(0, 1) ? 8 : ndig, 0);
    end else if (kind >= 70 && kind < 78) begin
      send_hex(value, 8, $urandom_range(1, 4));
    end else if (kind >= 78 && kind < 86) begin
      send_hex(value ^ (32'h1 << $urandom_range(0, 31)), 8, 0);
    end else if (kind >= 92) begin
      send_char(8'($urandom));
    end
    send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic write_mask(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SUM_MASK;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mask_m = value;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_read(7'd127);
    send_text(">A;41");
    send_char(CH_CR);
    send_read(7'd0);
    send_read(7'd1);
    send_text(">~ ;");
    send_char(CH_LF);
    send_text(">>");
    send_char(CH_LF);
    send_text("z");
    send_text(">;0");
    send_char(CH_CR);
    send_text(">Q");
    send_char(8'h7F);
    send_text(">;g");
    send_text(">;1");
    send_char(CH_LF);
  endtask

  task automatic test_frames(input logic [31:0] mask, input int n);
    int start;
    drain();
    write_mask(mask);
    start = item_count;
    while (item_count - start < n) begin
      send_frame();
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 9) < 7) send_read(7'($urandom_range(0, pub_len_m)));
        else send_read(7'($urandom));
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_CHAR;
    in_ch.char_in    = '0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_frames(32'h0000_00FF, 250);
    test_frames(32'hFFFF_FFFF, 250);
    test_frames(32'h0000_0000, 150);
    test_frames(32'h0000_FFFF, 200);
    test_frames($urandom, 150);
    test_frames(32'h0000_0F0F, 150);
    drain();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/acfp_pkg.sv
src/acfp_if.sv
src/acfp_ram.sv
src/acfp_parser.sv
src/acfp_out.sv
src/ascii_command_frame_parser_unit.sv
bench/testbench.sv
